FILE: rtl/mcma_pkg.sv
// Shared widths, defaults and sequencer state type for the moving average block.
`default_nettype none

package mcma_pkg;

   // Field widths of the request, response and window register.
   localparam int CHAN_W   = 2;
   localparam int SAMPLE_W = 32;
   localparam int WIN_W    = 9;

   // Default sizing of the sample store.
   localparam int WINDOW_MAX_DEF = 256;
   localparam int CHANNELS_DEF   = 3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/mcma_if.sv
// Request and response channel interfaces of the moving average block.
`default_nettype none

interface mcma_req_if;
   import mcma_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mcma_rsp_if;
   import mcma_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel_out;
   logic [SAMPLE_W-1:0] average;
   logic [WIN_W-1:0]    sample_count;

   modport source (output valid, output channel_out, output average, output sample_count,
                   input ready);
   modport sink   (input valid, input channel_out, input average, input sample_count,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/multi_channel_moving_average.sv
// Multi-channel moving average over a ring buffer per channel, top level.
//
// Each request names a channel and carries one unsigned 16.16 latency sample.
// The sample goes into that channel's ring in the sample store, the channel's
// running sum and fill count are updated, and one response returns the
// channel, the truncated average (sum / count) and the count.
// Requests for a channel beyond the configured count, or while the window is
// zero, change nothing and respond with average 0 and count 0.
// The window register is written through csr_wr_en / csr_wr_data; a write
// saturates the value to WINDOW_MAX and clears every channel's sum, ring
// position and fill count. Reset does the same with a window of zero.
// Sequence: one request at a time. A request passes through the read state,
// which issues the store read, the update state, which updates and writes
// back, the bit-serial divide state and the deliver state, which loads the
// response register. No new request is taken until the block is idle again.
// The response register holds its result while rsp_chan.ready is low; the
// block finishes the next request and then waits until the register frees.
`default_nettype none

module multi_channel_moving_average #(
   parameter int WINDOW_MAX = mcma_pkg::WINDOW_MAX_DEF,
   parameter int CHANNELS   = mcma_pkg::CHANNELS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [mcma_pkg::WIN_W-1:0] csr_wr_data,
   mcma_req_if.sink                      req_chan,
   mcma_rsp_if.source                    rsp_chan
);
   import mcma_pkg::*;

   localparam int POS_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH   = CHANNELS * WINDOW_MAX;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W   = (POS_W + 1 > WIN_W) ? POS_W + 1 : WIN_W;
   localparam int SUM_W   = SAMPLE_W + WIN_W;
   localparam int STEP_W  = $clog2(SUM_W);

   // Sequencer and request registers.
   state_type             state_ff, state_in;
   logic [CHAN_W-1:0]     ch_ff;
   logic [SAMPLE_W-1:0]   smp_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [ADDR_W-1:0]     slot_ff;
   logic [WIN_W-1:0]      window_ff;

   // Per-channel state.
   logic [SUM_W-1:0]      sum_ff  [CHANNELS];
   logic [POS_W-1:0]      wpos_ff [CHANNELS];
   logic [WIN_W-1:0]      fill_ff [CHANNELS];

   // Sample store.
   logic [SAMPLE_W-1:0]   sample_store_mem [DEPTH];
   logic [SAMPLE_W-1:0]   rd_data_ff;

   // Divider registers.
   logic [SUM_W-1:0]      quo_ff;
   logic [WIN_W-1:0]      rem_ff;
   logic [WIN_W-1:0]      div_cnt_ff;
   logic [STEP_W-1:0]     step_ff;

   // Response register.
   logic                  rsp_valid_ff;
   logic [CHAN_W-1:0]     out_ch_ff;
   logic [SAMPLE_W-1:0]   out_avg_ff;
   logic [WIN_W-1:0]      out_cnt_ff;

   // Control outputs of the sequencer.
   logic                  req_ready;
   logic                  mem_rd_en;
   logic                  mem_wr_en;
   logic                  load_out;

   logic                  req_fire;
   logic                  bypass;
   logic [CH_W-1:0]       ch_idx;
   logic [POS_W-1:0]      pos_cur;
   logic [ADDR_W-1:0]     slot_cur;
   logic                  win_full;
   logic [SUM_W-1:0]      sum_next;
   logic [WIN_W-1:0]      fill_next;
   logic [CMP_W-1:0]      pos_inc;
   logic [POS_W-1:0]      pos_next;
   logic [WIN_W:0]        div_shift;
   logic [WIN_W:0]        div_diff;
   logic                  div_bit;
   logic [WIN_W-1:0]      rem_in;
   logic                  step_last;

   assign req_fire = req_chan.valid && req_ready;
   assign bypass   = (32'(req_chan.channel) >= CHANNELS) || (window_ff == '0);
   assign ch_idx   = CH_W'(ch_ff);

   // Ring position of the channel, wrapped if the window shrank.
   always_comb begin
      pos_cur = wpos_ff[ch_idx];
      if (CMP_W'(pos_cur) >= CMP_W'(window_ff)) begin
         pos_cur = '0;
      end
      slot_cur = ADDR_W'(32'(ch_idx) * WINDOW_MAX) + ADDR_W'(pos_cur);
   end

   // Running sum, fill count and position update.
   always_comb begin
      win_full = fill_ff[ch_idx] >= window_ff;
      if (win_full) begin
         sum_next  = sum_ff[ch_idx] - SUM_W'(rd_data_ff) + SUM_W'(smp_ff);
         fill_next = fill_ff[ch_idx];
      end else begin
         sum_next  = sum_ff[ch_idx] + SUM_W'(smp_ff);
         fill_next = fill_ff[ch_idx] + WIN_W'(1);
      end
      pos_inc = CMP_W'(pos_ff) + CMP_W'(1);
      if (pos_inc >= CMP_W'(window_ff)) begin
         pos_next = '0;
      end else begin
         pos_next = POS_W'(pos_inc);
      end
   end

   // One restoring division step per cycle.
   always_comb begin
      div_shift = {rem_ff, quo_ff[SUM_W-1]};
      div_diff  = div_shift - {1'b0, div_cnt_ff};
      div_bit   = div_shift >= {1'b0, div_cnt_ff};
      if (div_bit) begin
         rem_in = div_diff[WIN_W-1:0];
      end else begin
         rem_in = div_shift[WIN_W-1:0];
      end
      step_last = step_ff == STEP_W'(SUM_W - 1);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = bypass ? ST_DELIVER : ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (step_last) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      mem_rd_en = 1'b0;
      mem_wr_en = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_READ:    mem_rd_en = 1'b1;
         ST_UPDATE:  mem_wr_en = 1'b1;
         ST_DIVIDE:  ;
         ST_DELIVER: load_out  = !rsp_valid_ff || rsp_chan.ready;
         default:    ;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Window register and per-channel state; a window write clears every channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]  <= '0;
            wpos_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         if (32'(csr_wr_data) > WINDOW_MAX) begin
            window_ff <= WIN_W'(WINDOW_MAX);
         end else begin
            window_ff <= csr_wr_data;
         end
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]  <= '0;
            wpos_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (mem_wr_en) begin
         sum_ff[ch_idx]  <= sum_next;
         wpos_ff[ch_idx] <= pos_next;
         fill_ff[ch_idx] <= fill_next;
      end
   end

   // Sample store. The write of one request lands before the next request's
   // read is issued, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= sample_store_mem[slot_cur];
      end
      if (mem_wr_en) begin
         sample_store_mem[slot_ff] <= smp_ff;
      end
   end

   // Request capture, slot latch and divider.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff      <= req_chan.channel;
         smp_ff     <= req_chan.sample;
         quo_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (mem_rd_en) begin
         pos_ff  <= pos_cur;
         slot_ff <= slot_cur;
      end
      if (mem_wr_en) begin
         quo_ff     <= sum_next;
         rem_ff     <= '0;
         div_cnt_ff <= fill_next;
         step_ff    <= '0;
      end else if (state_ff == ST_DIVIDE) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], div_bit};
         rem_ff  <= rem_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ch_ff  <= ch_ff;
         out_avg_ff <= quo_ff[SAMPLE_W-1:0];
         out_cnt_ff <= div_cnt_ff;
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.channel_out  = out_ch_ff;
   assign rsp_chan.average      = out_avg_ff;
   assign rsp_chan.sample_count = out_cnt_ff;

   // The divider never runs with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> div_cnt_ff != '0)
      else $error("divider running with zero count");

   // The partial remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < div_cnt_ff)
      else $error("division remainder out of range");

   // A response appears only after the deliver state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("response raised outside deliver state");

   // An empty window always reports a zero average.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_cnt_ff == '0 |-> out_avg_ff == '0)
      else $error("nonzero average with zero count");

endmodule

`default_nettype wire

FILE: bench/mcma_average_checker.sv
// Response checker for the moving average block: predicts every average and compares.
`timescale 1ns / 1ps

module mcma_average_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [mcma_pkg::WIN_W-1:0]    csr_wr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [mcma_pkg::CHAN_W-1:0]   req_channel,
   input  wire logic [mcma_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [mcma_pkg::CHAN_W-1:0]   rsp_channel_out,
   input  wire logic [mcma_pkg::SAMPLE_W-1:0] rsp_average,
   input  wire logic [mcma_pkg::WIN_W-1:0]    rsp_sample_count,
   output int                                 mismatch_count,
   output int                                 outstanding,
   output int                                 averages_checked,
   output int                                 evictions
);
   import mcma_pkg::*;

   localparam int CHANNELS   = CHANNELS_DEF;
   localparam int WINDOW_MAX = WINDOW_MAX_DEF;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] average;
      logic [WIN_W-1:0]    count;
   } average_result_type;

   // Shadow copy of the block's window register and per-channel ring state.
   logic [WIN_W-1:0]    win_setting;
   logic [SAMPLE_W-1:0] ring_samples [CHANNELS*WINDOW_MAX];
   logic [39:0]         channel_sum [CHANNELS];
   logic [WIN_W-1:0]    ring_position [CHANNELS];
   logic [WIN_W-1:0]    channel_fill [CHANNELS];

   average_result_type pending_averages [$];
   int                 mismatches;
   int                 checked;
   int                 evicted;

   assign mismatch_count   = mismatches;
   assign averages_checked = checked;
   assign evictions        = evicted;

   // Clears every channel's sum, ring position and fill count.
   function automatic void clear_channels();
      for (int c = 0; c < CHANNELS; c++) begin
         channel_sum[c]   = '0;
         ring_position[c] = '0;
         channel_fill[c]  = '0;
      end
   endfunction

   // Pushes one sample into its channel's ring and returns the average it yields.
   function automatic average_result_type predict_average(input logic [CHAN_W-1:0] ch,
                                                          input logic [SAMPLE_W-1:0] smp);
      average_result_type res;
      logic [WIN_W-1:0]   pos;
      logic [39:0]        quotient;
      int                 slot;
      res.channel = ch;
      res.average = '0;
      res.count   = '0;
      if (ch >= CHANNELS || win_setting == 0) begin
         return res;
      end
      pos = ring_position[ch];
      if (pos >= win_setting) begin
         pos = '0;
      end
      slot = ch * WINDOW_MAX + pos;
      // While filling the sum only grows; once full the oldest sample drops out.
      if (channel_fill[ch] < win_setting) begin
         channel_sum[ch]  = channel_sum[ch] + {8'd0, smp};
         channel_fill[ch] = channel_fill[ch] + 1'b1;
      end else begin
         channel_sum[ch] = channel_sum[ch] - {8'd0, ring_samples[slot]} + {8'd0, smp};
         evicted++;
      end
      ring_samples[slot] = smp;
      pos = pos + 1'b1;
      if (pos >= win_setting) begin
         pos = '0;
      end
      ring_position[ch] = pos;
      quotient    = channel_sum[ch] / {31'd0, channel_fill[ch]};
      res.average = quotient[SAMPLE_W-1:0];
      res.count   = channel_fill[ch];
      return res;
   endfunction

   // Track register writes and requests, then match each response to the oldest prediction.
   always @(posedge clock) begin
      average_result_type got;
      average_result_type want;
      if (reset) begin
         win_setting = '0;
         clear_channels();
         pending_averages.delete();
         mismatches = 0;
         checked    = 0;
         evicted    = 0;
      end else begin
         if (csr_wr_en) begin
            win_setting = (csr_wr_data > WINDOW_MAX) ? WIN_W'(WINDOW_MAX) : csr_wr_data;
            clear_channels();
         end
         // A response can never belong to a request taken on the same edge.
         if (rsp_valid && rsp_ready) begin
            got.channel = rsp_channel_out;
            got.average = rsp_average;
            got.count   = rsp_sample_count;
            if (pending_averages.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("[%0t] unexpected response: channel %0d average %h count %0d",
                           $realtime, got.channel, got.average, got.count);
               end
            end else begin
               want = pending_averages.pop_front();
               checked++;
               if (got.channel !== want.channel || got.average !== want.average ||
                   got.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("[%0t] response mismatch: expected channel %0d average %h count %0d",
                              $realtime, want.channel, want.average, want.count);
                     $display("[%0t]                    got      channel %0d average %h count %0d",
                              $realtime, got.channel, got.average, got.count);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_averages.push_back(predict_average(req_channel, req_sample));
         end
      end
      outstanding <= pending_averages.size();
   end

endmodule

FILE: bench/tb_multi_channel_moving_average.sv
// Testbench top for the moving average block: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_multi_channel_moving_average;
   import mcma_pkg::*;

   localparam int CHANNELS          = CHANNELS_DEF;
   localparam int DRAIN_CYCLES      = 50;
   localparam int LONG_STALL_CYCLES = 600;
   localparam int WATCHDOG_LIMIT    = 5000;
   localparam int PHASES            = 7;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_SEND_IDLE,
      FLOW_RECV_STALL,
      FLOW_BOTH
   } flow_mode_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [WIN_W-1:0] csr_wr_data;

   mcma_req_if req_chan ();
   mcma_rsp_if rsp_chan ();

   flow_mode_type flow_mode = FLOW_FREE;
   int            stall_requests = 0;
   int            stalls_started = 0;
   int            stall_left = 0;
   int            quiet_cycles = 0;
   int            requests_sent = 0;
   int            windows_used = 0;

   int mismatch_count;
   int outstanding;
   int averages_checked;
   int evictions;

   multi_channel_moving_average u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   mcma_average_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_channel      (req_chan.channel),
      .req_sample       (req_chan.sample),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_channel_out  (rsp_chan.channel_out),
      .rsp_average      (rsp_chan.average),
      .rsp_sample_count (rsp_chan.sample_count),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding),
      .averages_checked (averages_checked),
      .evictions        (evictions)
   );

   // Free-running 8 ns clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic sender_idles();
      case (flow_mode)
         FLOW_SEND_IDLE: return $urandom_range(99) < 63;
         FLOW_BOTH:      return $urandom_range(99) < 18;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_stalls();
      case (flow_mode)
         FLOW_RECV_STALL: return $urandom_range(99) < 63;
         FLOW_BOTH:       return $urandom_range(99) < 18;
         default:         return 1'b0;
      endcase
   endfunction

   // Response ready: random stalls per mode, plus one long hold-off on demand.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stalls_started < stall_requests) begin
         stalls_started++;
         stall_left = LONG_STALL_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !receiver_stalls();
      end
   end

   // Watchdog: ends the run when no request or response moves for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request, with random idle cycles ahead of it, and waits for acceptance.
   task automatic send_request(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
      while (sender_idles()) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.channel <= ch;
      req_chan.sample  <= smp;
      do @(posedge clock); while (!req_chan.ready);
      requests_sent++;
   endtask

   // Stops offering and waits until every predicted response has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      windows_used++;
   endtask

   // Mostly in-range channels; a focused phase leans on channel 0 so its ring wraps.
   function automatic logic [CHAN_W-1:0] pick_channel(input logic focus);
      if ($urandom_range(99) < 5) begin
         return CHAN_W'(3);
      end
      if (focus) begin
         return ($urandom_range(99) < 70) ? CHAN_W'(0) : CHAN_W'($urandom_range(1, 2));
      end
      return CHAN_W'($urandom_range(0, CHANNELS - 1));
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(0, 255));
         3, 4:    return SAMPLE_W'($urandom_range(32'h0000_8000, 32'h0040_0000));
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // One random phase: new window, a flow mode, and an optional long response hold-off.
   task automatic run_phase(input logic [WIN_W-1:0] win, input int n_items,
                            input flow_mode_type mode, input logic pressure);
      int               counted;
      logic [CHAN_W-1:0] ch;
      logic              focus;
      counted = 0;
      focus   = (win >= 255);
      wait_drained();
      flow_mode = FLOW_FREE;
      write_window(win);
      flow_mode = mode;
      while (counted < n_items) begin
         ch = pick_channel(focus);
         send_request(ch, pick_sample());
         if (ch < CHANNELS) begin
            counted++;
            if (pressure && counted == 40) begin
               stall_requests++;
            end
         end
      end
   endtask

   // Main sequence: reset, directed corner cases, then random phases.
   initial begin
      int            win_plan [PHASES];
      int            count_plan [PHASES];
      flow_mode_type mode_plan [PHASES];

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.channel <= '0;
      req_chan.sample  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Window is zero out of reset: samples are ignored.
      send_request(2'd0, 32'hFFFF_FFFF);
      send_request(2'd3, 32'h1234_5678);

      // Two-sample window: full-scale sums, eviction and the unused channel.
      wait_drained();
      write_window(9'd2);
      send_request(2'd0, 32'hFFFF_FFFF);
      send_request(2'd0, 32'hFFFF_FFFF);
      send_request(2'd0, 32'hFFFF_FFFF);
      send_request(2'd1, 32'h0000_0000);
      send_request(2'd2, 32'h0000_0001);
      send_request(2'd2, 32'h0000_0002);
      send_request(2'd2, 32'h0000_0003);
      send_request(2'd3, 32'hFFFF_FFFF);

      // All-ones window value saturates to the largest window.
      wait_drained();
      write_window(9'h1FF);
      send_request(2'd1, 32'hFFFF_FFFF);
      send_request(2'd1, 32'hFFFF_FFFF);
      send_request(2'd1, 32'h0000_0000);
      send_request(2'd2, 32'h0001_8000);

      // Writing zero disables every channel again.
      wait_drained();
      write_window(9'd0);
      send_request(2'd0, 32'h0001_0000);
      send_request(2'd2, 32'hDEAD_BEEF);

      win_plan   = '{1, 3, 256, $urandom_range(4, 16), 255, $urandom_range(2, 32), 0};
      count_plan = '{150, 200, 700, 260, 200, 300, 40};
      mode_plan  = '{FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH,
                     FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH};
      for (int p = 0; p < PHASES; p++) begin
         run_phase(WIN_W'(win_plan[p]), count_plan[p], mode_plan[p], p == 5);
      end

      flow_mode = FLOW_FREE;
      wait_drained();

      $display("Sent %0d requests under %0d window settings, disabled and unused channels included.",
               requests_sent, windows_used);
      $display("Compared %0d averages; %0d ring evictions predicted.",
               averages_checked, evictions);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d responses missing.", mismatch_count, outstanding);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
